[sv/spa_pkg.sv]
`timescale 1ns / 1ps

package spa_pkg;

  // Handle space of the slot field; the pool itself may be smaller.
  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 5;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } spa_func_e;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_FULL       = 3'd1,
    ST_FREED      = 3'd2,
    ST_FREED_IDLE = 3'd3,
    ST_UNKNOWN    = 3'd4
  } spa_status_e;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
  } spa_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] in_use_count;
    logic [COUNT_W-1:0] peak_level;
  } spa_rsp_t;

endpackage

[sv/spa_if.sv]
`timescale 1ns / 1ps

interface spa_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [3:0] slot;

  modport source (output valid, output func, output slot, input ready);
  modport sink   (input valid, input func, input slot, output ready);
endinterface

interface spa_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] granted_slot;
  logic [4:0] in_use_count;
  logic [4:0] peak_level;

  modport source (output valid, output status, output granted_slot,
                  output in_use_count, output peak_level, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input in_use_count, input peak_level, output ready);
endinterface

[sv/slot_pool_allocator.sv]
`timescale 1ns / 1ps

// Bitmap first-fit slot allocator. Each request (allocate, or free a handle)
// is taken into an input register, resolved against the in-use bitmap by
// combinational logic, and its result lands in an output register; one
// request per cycle is sustained while the result side keeps taking items,
// and a stalled result stalls the input register behind it. Allocation
// grants the lowest free slot; handles at or above SLOT_COUNT (1 to 16) come
// back as unknown. After reset all slots are free and the peak is zero.
module slot_pool_allocator #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spa_req_if.sink          req_i,
  spa_rsp_if.source        rsp_o
);
  import spa_pkg::*;

  logic     in_vld_q, out_vld_q;
  spa_req_t in_q;
  spa_rsp_t out_q, rsp;
  logic     step;

  assign step        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || step;

  spa_pool #(.SLOT_COUNT(SLOT_COUNT)) u_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_vld_q <= req_i.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.func <= req_i.func;
      in_q.slot <= req_i.slot;
    end
    if (step) begin
      out_q <= rsp;
    end
  end

  assign rsp_o.valid        = out_vld_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.granted_slot = out_q.granted_slot;
  assign rsp_o.in_use_count = out_q.in_use_count;
  assign rsp_o.peak_level   = out_q.peak_level;

endmodule

[sv/spa_first_free.sv]
`timescale 1ns / 1ps

module spa_first_free (
  input  logic [spa_pkg::MAX_SLOTS-1:0] free_i,
  output logic                          found_o,
  output logic [spa_pkg::MAX_SLOTS-1:0] onehot_o,
  output logic [spa_pkg::SLOT_W-1:0]    idx_o
);
  import spa_pkg::*;

  logic [MAX_SLOTS-1:0] lowest;

  // Isolate the lowest set bit.
  assign lowest   = free_i & (~free_i + MAX_SLOTS'(1));
  assign found_o  = |free_i;
  assign onehot_o = lowest;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      idx_o = idx_o | (lowest[i] ? SLOT_W'(i) : '0);
    end
  end

endmodule

[sv/spa_pool.sv]
`timescale 1ns / 1ps

module spa_pool #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  spa_pkg::spa_req_t req_i,
  output spa_pkg::spa_rsp_t rsp_o
);
  import spa_pkg::*;

  localparam logic [COUNT_W-1:0] PoolSize = COUNT_W'(SLOT_COUNT);

  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [COUNT_W-1:0]    peak_q, peak_d;

  logic [MAX_SLOTS-1:0]  busy_ext, pool_mask, free_ext, grant_oh, clr_oh;
  logic                  any_free;
  logic [SLOT_W-1:0]     grant_idx;
  logic [COUNT_W-1:0]    count_inc;

  assign busy_ext  = MAX_SLOTS'(busy_q);
  assign pool_mask = MAX_SLOTS'({SLOT_COUNT{1'b1}});
  assign free_ext  = ~busy_ext & pool_mask;
  assign clr_oh    = MAX_SLOTS'(1) << req_i.slot;
  assign count_inc = count_q + COUNT_W'(1);

  spa_first_free u_first_free (
    .free_i   (free_ext),
    .found_o  (any_free),
    .onehot_o (grant_oh),
    .idx_o    (grant_idx)
  );

  always_comb begin
    busy_d             = busy_q;
    count_d            = count_q;
    peak_d             = peak_q;
    rsp_o.granted_slot = '0;
    rsp_o.status       = ST_FULL;
    if (req_i.func == FUNC_ALLOC) begin
      if (any_free) begin
        busy_d             = busy_q | grant_oh[SLOT_COUNT-1:0];
        count_d            = count_inc;
        rsp_o.status       = ST_GRANTED;
        rsp_o.granted_slot = grant_idx;
        if (count_inc > peak_q) begin
          peak_d = count_inc;
        end
      end
    end else if ({1'b0, req_i.slot} >= PoolSize) begin
      rsp_o.status = ST_UNKNOWN;
    end else if (busy_ext[req_i.slot]) begin
      busy_d       = busy_q & ~clr_oh[SLOT_COUNT-1:0];
      count_d      = count_q - COUNT_W'(1);
      rsp_o.status = ST_FREED;
    end else begin
      rsp_o.status = ST_FREED_IDLE;
    end
    rsp_o.in_use_count = count_d;
    rsp_o.peak_level   = peak_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      count_q <= '0;
      peak_q  <= '0;
    end else if (step_i) begin
      busy_q  <= busy_d;
      count_q <= count_d;
      peak_q  <= peak_d;
    end
  end

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == COUNT_W'($countones(busy_q)))
    else $error("in-use count out of step with busy map");

  a_peak_covers_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= count_q)
    else $error("peak below in-use count");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rsp_o.status == ST_FULL |-> count_q == PoolSize)
    else $error("pool full reported with a free slot");

  a_grant_sets_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && rsp_o.status == ST_GRANTED |=> count_q == $past(count_q) + COUNT_W'(1))
    else $error("grant did not raise the in-use count");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import spa_pkg::*;

  localparam int unsigned SLOT_COUNT   = 8;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned TAIL_CYCLES  = 8;

  typedef struct {
    spa_req_t req;
    bit       drain;  // wait for every result before offering this item
  } pending_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spa_req_if req_if ();
  spa_rsp_if rsp_if ();

  slot_pool_allocator #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  pending_req_t pending_q[$];
  spa_rsp_t     expected_q[$];

  // Pool state as the requests accepted so far leave it.
  logic [SLOT_COUNT-1:0] pool_busy = '0;
  logic [COUNT_W-1:0]    pool_peak = '0;

  int unsigned sent_count;
  int unsigned recv_count;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned send_steady;
  int unsigned hold_gap;
  int unsigned recv_steady;
  bit          long_hold_done;

  function automatic spa_rsp_t apply_request(spa_req_t r);
    spa_rsp_t rsp;
    bit       found;
    rsp   = '0;
    found = 1'b0;
    if (spa_func_e'(r.func) == FUNC_ALLOC) begin
      rsp.status = ST_FULL;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!found && !pool_busy[i]) begin
          found             = 1'b1;
          pool_busy[i]      = 1'b1;
          rsp.granted_slot  = SLOT_W'(i);
          rsp.status        = ST_GRANTED;
        end
      end
    end else if (r.slot >= SLOT_COUNT) begin
      rsp.status = ST_UNKNOWN;
    end else begin
      rsp.status = pool_busy[r.slot] ? ST_FREED : ST_FREED_IDLE;
      pool_busy[r.slot] = 1'b0;
    end
    rsp.in_use_count = COUNT_W'($countones(pool_busy));
    // only a grant can raise the peak
    if (rsp.status == ST_GRANTED && rsp.in_use_count > pool_peak) begin
      pool_peak = rsp.in_use_count;
    end
    rsp.peak_level = pool_peak;
    return rsp;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned next_gap(ref int unsigned steady);
    int unsigned r;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic queue_item(spa_func_e f, logic [SLOT_W-1:0] s, bit drain);
    pending_req_t item;
    item.req.func = f;
    item.req.slot = s;
    item.drain    = drain;
    pending_q.push_back(item);
  endtask

  task automatic check_field(string field, logic [COUNT_W-1:0] want_v,
                             logic [COUNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      error_count++;
    end
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    logic         next_valid;
    int unsigned  in_flight;
    pending_req_t done;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.func  <= FUNC_ALLOC;
      req_if.slot  <= '0;
      sent_count   <= 0;
      send_gap      = 0;
      send_steady   = 0;
    end else begin
      next_valid = req_if.valid;
      in_flight  = sent_count - recv_count;
      if (req_if.valid && req_if.ready) begin
        done = pending_q.pop_front();
        expected_q.push_back(apply_request(done.req));
        sent_count <= sent_count + 1;
        in_flight++;
        next_valid = 1'b0;
        send_gap   = next_gap(send_steady);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 && !(pending_q[0].drain && in_flight != 0)) begin
          next_valid = 1'b1;
          req_if.func <= pending_q[0].req.func;
          req_if.slot <= pending_q[0].req.slot;
        end
      end
      req_if.valid <= next_valid;
    end
  end

  // Result-side ready, with one long hold-off to back the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready  <= 1'b0;
      hold_gap       = 0;
      recv_steady    = 0;
      long_hold_done = 1'b0;
    end else begin
      if (!long_hold_done && recv_count >= HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_gap       = LONG_HOLD;
      end
      if (hold_gap > 0) begin
        hold_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        hold_gap = next_gap(recv_steady);
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    spa_rsp_t want;
    if (!rst_ni) begin
      recv_count <= 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      recv_count <= recv_count + 1;
      if (expected_q.size() == 0) begin
        $error("result item with no request outstanding");
        error_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", COUNT_W'(want.status), COUNT_W'(rsp_if.status));
        check_field("granted_slot", COUNT_W'(want.granted_slot),
                    COUNT_W'(rsp_if.granted_slot));
        check_field("in_use_count", want.in_use_count, rsp_if.in_use_count);
        check_field("peak_level", want.peak_level, rsp_if.peak_level);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned total_items;
    int unsigned alloc_pct;
    int unsigned run_len;
    int unsigned n;
    logic [SLOT_W-1:0] s;

    req_if.valid = 1'b0;
    req_if.func  = FUNC_ALLOC;
    req_if.slot  = '0;
    rsp_if.ready = 1'b0;
    error_count  = 0;
    idle_cycles  = 0;

    // Fill the pool, then one allocate past full.
    for (int i = 0; i <= SLOT_COUNT; i++) begin
      queue_item(FUNC_ALLOC, (i % 2) ? 4'hF : 4'h0, 1'b0);
    end
    queue_item(FUNC_FREE, SLOT_W'(SLOT_COUNT), 1'b0);
    queue_item(FUNC_FREE, 4'hF, 1'b0);
    queue_item(FUNC_FREE, 4'd3, 1'b0);
    queue_item(FUNC_FREE, 4'd3, 1'b0);          // double free
    queue_item(FUNC_ALLOC, 4'hA, 1'b0);         // refills the hole, peak holds
    queue_item(FUNC_FREE, 4'd0, 1'b0);
    queue_item(FUNC_FREE, SLOT_W'(SLOT_COUNT - 1), 1'b0);
    queue_item(FUNC_ALLOC, 4'h5, 1'b0);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      queue_item(FUNC_FREE, SLOT_W'(i), 1'b0);
    end

    // Random phases that lean toward filling or draining the pool, or balance it.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0:       alloc_pct = 85;
        1:       alloc_pct = 50;
        default: alloc_pct = 20;
      endcase
      run_len = $urandom_range(10, 40);
      for (int k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 99) < 85) s = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        else s = SLOT_W'($urandom_range(0, 15));
        queue_item(($urandom_range(0, 99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE, s,
                   (n == 0) || ($urandom_range(0, 99) == 0));
        n++;
      end
    end
    total_items = pending_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_count < total_items || recv_count < sent_count) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      $error("%0d expected result items never arrived", expected_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[slot_pool_allocator.f]
sv/spa_pkg.sv
sv/spa_if.sv
sv/spa_first_free.sv
sv/spa_pool.sv
sv/slot_pool_allocator.sv
tb/sv/testbench.sv
